// ----- rtl/center_crop_error_diffusion_dither_defines.svh -----
// ----------------------------------------------------------------------------
// center_crop_error_diffusion_dither_defines
// assertion macros shared by the dither rtl
// ----------------------------------------------------------------------------
`ifndef CENTER_CROP_ERROR_DIFFUSION_DITHER_DEFINES_SVH
`define CENTER_CROP_ERROR_DIFFUSION_DITHER_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define CCDITH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk outside reset
`define CCDITH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ccdith_pkg.sv -----
// ----------------------------------------------------------------------------
// ccdith_pkg
// shared constants, types and the error diffusion step of the crop dither
// ----------------------------------------------------------------------------
package ccdith_pkg;

    localparam int DISPLAY_WIDTH  = 256;
    localparam int DISPLAY_HEIGHT = 128;

    localparam int COUNT_W = 12;
    localparam int DX_W    = $clog2(DISPLAY_WIDTH);
    localparam int ERR_W   = 8;

    localparam logic [COUNT_W-1:0] SOURCE_WIDTH_RESET  = 12'd320;
    localparam logic [COUNT_W-1:0] SOURCE_HEIGHT_RESET = 12'd240;
    localparam logic [COUNT_W-1:0] ROW_MAX             = 12'hFFF;

    localparam logic [2:0] WEIGHT_UPPER_LEFT  = 3'd1;
    localparam logic [2:0] WEIGHT_UPPER       = 3'd5;
    localparam logic [2:0] WEIGHT_UPPER_RIGHT = 3'd3;
    localparam logic [2:0] WEIGHT_LEFT        = 3'd7;

    typedef enum logic [0:0] {
        CFG_SOURCE_WIDTH  = 1'b0,
        CFG_SOURCE_HEIGHT = 1'b1
    } cfg_index_t;

    // acc + err * weight / 16 (truncated toward zero), clamped to 0..255
    function automatic logic [7:0] add_clamp(input logic [7:0] acc,
                                             input logic [ERR_W-1:0] err,
                                             input logic [2:0] weight);
        logic signed [11:0] prod;
        logic signed [11:0] quot;
        logic signed [11:0] sum;
        logic [7:0]         res;
        prod = $signed(err) * $signed({1'b0, weight});
        if (prod[11])
        begin
            quot = (prod + 12'sd15) >>> 4;
        end
        else
        begin
            quot = prod >>> 4;
        end
        sum = $signed({4'b0000, acc}) + quot;
        if (sum < 12'sd0)
        begin
            res = 8'd0;
        end
        else if (sum > 12'sd255)
        begin
            res = 8'd255;
        end
        else
        begin
            res = sum[7:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/ccdith_ram.sv -----
// ----------------------------------------------------------------------------
// ccdith_ram
// generic ram, one write port, two registered read ports, read returns old data
// ----------------------------------------------------------------------------
module ccdith_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- rtl/center_crop_error_diffusion_dither.sv -----
// ----------------------------------------------------------------------------
// center_crop_error_diffusion_dither
// centre crop of a grayscale stream and 1-bit floyd-steinberg dither
// ----------------------------------------------------------------------------
// Takes one camera pixel per clock and gives one black/white pixel per clock
// for pixels inside the centred display window while the output is not
// stalled; pixels outside it are taken and dropped. A kept pixel is held in
// the second-stage registers after its beat is taken and moves on into the
// output register once that register is free. The error line of the previous
// display row sits in a two-read-port memory: the pixel above and the pixel
// above-right are read when the beat is taken, and the new error is written
// back as the pixel leaves the second stage, with write-through forwarding to
// the next read. Left and upper-left errors are held in registers. The input
// stalls only while a kept pixel waits behind a stalled output register.
// ----------------------------------------------------------------------------
`include "center_crop_error_diffusion_dither_defines.svh"

module center_crop_error_diffusion_dither
    import ccdith_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  cfg_index_t         cfg_index,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         gray,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               pixel_black,
    output logic               line_end,
    output logic               frame_end
);

    localparam logic [COUNT_W-1:0] DISP_W_C = COUNT_W'(DISPLAY_WIDTH);
    localparam logic [COUNT_W-1:0] DISP_H_C = COUNT_W'(DISPLAY_HEIGHT);
    localparam logic [DX_W-1:0]    LAST_DX  = DX_W'(DISPLAY_WIDTH - 1);

    // configuration
    logic [COUNT_W-1:0] source_width_reg;
    logic [COUNT_W-1:0] source_height_reg;

    // position counters
    logic [COUNT_W-1:0] column_reg;
    logic [COUNT_W-1:0] row_reg;

    // second stage
    logic             s1_valid_reg;
    logic [7:0]       s1_gray_reg;
    logic [DX_W-1:0]  s1_dx_reg;
    logic             s1_top_row_reg;
    logic             s1_line_end_reg;
    logic             s1_frame_end_reg;
    logic             s1_fwd_a_reg;
    logic             s1_fwd_b_reg;
    logic [ERR_W-1:0] fwd_data_reg;

    // neighbour errors
    logic [ERR_W-1:0] left_error_reg;
    logic [ERR_W-1:0] upper_left_error_reg;

    // output register
    logic out_valid_reg;
    logic pixel_black_reg;
    logic line_end_reg;
    logic frame_end_reg;

    logic               in_accept;
    logic               out_free;
    logic               advance;
    logic [COUNT_W-1:0] column_cur;
    logic [COUNT_W-1:0] row_cur;
    logic [COUNT_W-1:0] crop_x;
    logic [COUNT_W-1:0] crop_y;
    logic [COUNT_W-1:0] col_off;
    logic [COUNT_W-1:0] row_off;
    logic               size_ok;
    logic               keep;
    logic [DX_W-1:0]    dx;
    logic [DX_W-1:0]    raddr_b;
    logic [COUNT_W:0]   column_inc;
    logic [COUNT_W-1:0] column_next;
    logic [COUNT_W-1:0] row_next;
    logic               ram_re;
    logic               ram_we;
    logic [ERR_W-1:0]   rd_a;
    logic [ERR_W-1:0]   rd_b;
    logic [ERR_W-1:0]   above;
    logic [ERR_W-1:0]   above_right;
    logic [7:0]         v1;
    logic [7:0]         v2;
    logic [7:0]         v3;
    logic [7:0]         v4;
    logic [ERR_W-1:0]   qerr;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // window position of the incoming beat
    always_comb
    begin
        column_cur = frame_start ? '0 : column_reg;
        row_cur    = frame_start ? '0 : row_reg;
        size_ok    = (source_width_reg >= DISP_W_C) && (source_height_reg >= DISP_H_C);
        crop_x     = (source_width_reg - DISP_W_C) >> 1;
        crop_y     = (source_height_reg - DISP_H_C) >> 1;
        col_off    = column_cur - crop_x;
        row_off    = row_cur - crop_y;
        keep       = size_ok && (column_cur >= crop_x) && (col_off < DISP_W_C)
                     && (row_cur >= crop_y) && (row_off < DISP_H_C);
        dx         = col_off[DX_W-1:0];
        raddr_b    = (dx == LAST_DX) ? dx : dx + 1'b1;
        column_inc = {1'b0, column_cur} + 1'b1;
        if (column_inc >= {1'b0, source_width_reg})
        begin
            column_next = '0;
            row_next    = (row_cur != ROW_MAX) ? row_cur + 1'b1 : row_cur;
        end
        else
        begin
            column_next = column_inc[COUNT_W-1:0];
            row_next    = row_cur;
        end
    end

    assign ram_re = in_accept && keep;
    assign ram_we = advance;

    ccdith_ram #(
        .WIDTH (ERR_W),
        .DEPTH (DISPLAY_WIDTH)
    ) u_error_line (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (s1_dx_reg),
        .wdata   (qerr),
        .re      (ram_re),
        .raddr_a (dx),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // diffusion of the neighbour errors, in upper-left, upper, upper-right, left order
    always_comb
    begin
        above       = s1_fwd_a_reg ? fwd_data_reg : rd_a;
        above_right = s1_fwd_b_reg ? fwd_data_reg : rd_b;
        v1 = (!s1_top_row_reg && s1_dx_reg != '0)
             ? add_clamp(s1_gray_reg, upper_left_error_reg, WEIGHT_UPPER_LEFT) : s1_gray_reg;
        v2 = !s1_top_row_reg ? add_clamp(v1, above, WEIGHT_UPPER) : v1;
        v3 = (!s1_top_row_reg && !s1_line_end_reg)
             ? add_clamp(v2, above_right, WEIGHT_UPPER_RIGHT) : v2;
        v4 = (s1_dx_reg != '0) ? add_clamp(v3, left_error_reg, WEIGHT_LEFT) : v3;
        // v - 255 wraps to v + 1 in eight bits
        qerr = v4[7] ? v4 + 1'b1 : v4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg     <= SOURCE_WIDTH_RESET;
            source_height_reg    <= SOURCE_HEIGHT_RESET;
            column_reg           <= '0;
            row_reg              <= '0;
            s1_valid_reg         <= 1'b0;
            s1_fwd_a_reg         <= 1'b0;
            s1_fwd_b_reg         <= 1'b0;
            left_error_reg       <= '0;
            upper_left_error_reg <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_data;
                    CFG_SOURCE_HEIGHT: source_height_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (in_accept)
            begin
                column_reg <= column_next;
                row_reg    <= row_next;
            end

            if (in_accept || advance)
            begin
                s1_valid_reg <= ram_re;
            end

            if (ram_re)
            begin
                s1_fwd_a_reg <= ram_we && (s1_dx_reg == dx);
                s1_fwd_b_reg <= ram_we && (s1_dx_reg == raddr_b);
            end

            if (advance)
            begin
                left_error_reg       <= qerr;
                upper_left_error_reg <= above;
            end

            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            s1_gray_reg      <= gray;
            s1_dx_reg        <= dx;
            s1_top_row_reg   <= (row_off == '0);
            s1_line_end_reg  <= (dx == LAST_DX);
            s1_frame_end_reg <= (dx == LAST_DX) && (row_off == DISP_H_C - 1'b1);
            fwd_data_reg     <= qerr;
        end
        if (advance)
        begin
            pixel_black_reg <= !v4[7];
            line_end_reg    <= s1_line_end_reg;
            frame_end_reg   <= s1_frame_end_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_black = pixel_black_reg;
    assign line_end    = line_end_reg;
    assign frame_end   = frame_end_reg;

    `CCDITH_ASSERT_NOW(a_hold_input, s1_valid_reg && out_valid_reg && out_stall, in_stall,
        "beat taken while a kept pixel waits behind a stalled output")
    `CCDITH_ASSERT_NEXT(a_read_enters_stage, ram_re, s1_valid_reg,
        "line read issued but no pixel in the second stage")
    `CCDITH_ASSERT_NEXT(a_no_forward_without_write, ram_re && !ram_we,
        !s1_fwd_a_reg && !s1_fwd_b_reg, "forwarding flag set without a write back")
    `CCDITH_ASSERT_NOW(a_frame_end_on_line_end, out_valid_reg && frame_end_reg, line_end_reg,
        "frame end given off the last column")

endmodule
